[hw/rtl/lfrc_pkg.sv]
// Shared types and constants of the line follower route controller.
package lfrc_pkg;

  localparam int unsigned RouteMax = 8;

  typedef enum logic [2:0] {
    RegRouteCodes   = 3'd0,
    RegRouteLength  = 3'd1,
    RegSampleWindow = 3'd2,
    RegQualifyBound = 3'd3,
    RegTurnHoldMs   = 3'd4,
    RegForwardWidth = 3'd5,
    RegStopWidth    = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    PhFollow = 4'd0,
    PhSteerR = 4'd1,
    PhSteerL = 4'd2,
    PhHold   = 4'd3,
    PhAlign  = 4'd4,
    PhPass   = 4'd5,
    PhFin1   = 4'd6,
    PhFinR   = 4'd7,
    PhFin2   = 4'd8,
    PhFinL   = 4'd9,
    PhDone   = 4'd10
  } phase_e;

  localparam logic [1:0] CodeLeft  = 2'd1;
  localparam logic [1:0] CodeRight = 2'd2;

  localparam logic [15:0] RouteCodesRst   = 16'd9609;
  localparam logic [3:0]  RouteLengthRst  = 4'd7;
  localparam logic [7:0]  SampleWindowRst = 8'd100;
  localparam logic [7:0]  QualifyBoundRst = 8'd80;
  localparam logic [9:0]  TurnHoldMsRst   = 10'd500;
  localparam logic [9:0]  ForwardWidthRst = 10'd130;
  localparam logic [9:0]  StopWidthRst    = 10'd200;

  typedef struct packed {
    logic [15:0] route_codes;
    logic [3:0]  route_length;
    logic [7:0]  sample_window;
    logic [7:0]  qualify_bound;
    logic [9:0]  turn_hold_ms;
    logic [9:0]  forward_width;
    logic [9:0]  stop_width;
  } cfg_t;

  typedef struct packed {
    logic mid_left_raw;
    logic mid_right_raw;
    logic left_wing_raw;
    logic right_wing_raw;
    logic ms_tick;
  } in_item_t;

  typedef struct packed {
    logic [9:0] left_width;
    logic [9:0] right_width;
    logic [3:0] route_position;
    logic [3:0] phase;
    logic       done_res;
  } out_item_t;

  // Classified sample handed from front to back; levels bit 0 mid-left .. bit 3 right wing.
  typedef struct packed {
    logic       win_end;
    logic [3:0] levels;
    logic       ms_tick;
  } cls_item_t;

endpackage

[hw/rtl/lfrc_fifo.sv]
// Small register queue used between the front, the back and the result port.
module lfrc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

endmodule

[hw/rtl/lfrc_front.sv]
// Front part: sensor window counting and qualification of raw samples.
module lfrc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfrc_pkg::cfg_t      cfg_i,
  input  logic                accept_i,
  input  lfrc_pkg::in_item_t  item_i,
  output lfrc_pkg::cls_item_t cls_o
);
  import lfrc_pkg::*;

  logic [3:0][7:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0]      wpos_q, wpos_d, wpos_inc;
  logic [3:0]      raw, qual;
  logic            win_end;

  assign raw = {item_i.right_wing_raw, item_i.left_wing_raw,
                item_i.mid_right_raw, item_i.mid_left_raw};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cnt_inc[k] = (raw[k] && cnt_q[k] != 8'hFF) ? cnt_q[k] + 8'd1 : cnt_q[k];
      qual[k]    = (cnt_inc[k] >= cfg_i.qualify_bound);
    end
    wpos_inc = wpos_q + 8'd1;
    win_end  = (wpos_inc >= cfg_i.sample_window) || (wpos_inc == 8'd0);
    cnt_d    = win_end ? '0 : cnt_inc;
    wpos_d   = win_end ? 8'd0 : wpos_inc;
  end

  assign cls_o.win_end = win_end;
  assign cls_o.levels  = qual;
  assign cls_o.ms_tick = item_i.ms_tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wpos_q <= '0;
    end else if (accept_i) begin
      cnt_q  <= cnt_d;
      wpos_q <= wpos_d;
    end
  end

  a_win_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && win_end) |=> (cnt_q == '0 && wpos_q == 8'd0))
    else $error("window end did not clear counters");

endmodule

[hw/rtl/lfrc_back.sv]
// Back part: route phase machine, turn hold timer and wheel widths.
module lfrc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfrc_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  input  lfrc_pkg::cls_item_t  cls_i,
  output logic                 pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output lfrc_pkg::out_item_t  res_o
);
  import lfrc_pkg::*;

  typedef enum logic [1:0] {
    DrvFwd   = 2'd0,
    DrvLeft  = 2'd1,
    DrvRight = 2'd2
  } drv_e;

  localparam logic [4:0] RouteMaxW = 5'(RouteMax);

  phase_e     ph_q, ph_d, ph_a, sc_ph;
  drv_e       drv_q, drv_d, sc_drv;
  logic [3:0] idx_q, idx_d, idx_inc;
  logic [9:0] tmr_q, tmr_d;
  logic [4:0] used_len;
  logic [1:0] code;
  logic       ml, mr, wing, step;

  assign step       = valid_i && !res_full_i;
  assign pop_o      = step;
  assign res_push_o = step;

  assign ml       = cls_i.levels[0];
  assign mr       = cls_i.levels[1];
  assign wing     = cls_i.levels[2] || cls_i.levels[3];
  assign used_len = ({1'b0, cfg_i.route_length} < RouteMaxW) ?
                    {1'b0, cfg_i.route_length} : RouteMaxW;
  assign code     = cfg_i.route_codes[{idx_q[2:0], 1'b0} +: 2];
  assign idx_inc  = idx_q + 4'd1;
  assign sc_ph    = (!mr && ml) ? PhFinL : PhDone;
  assign sc_drv   = (!mr && ml) ? DrvLeft : DrvFwd;

  always_comb begin
    ph_a  = ph_q;
    tmr_d = tmr_q;
    if (ph_q == PhHold) begin
      if (cls_i.ms_tick && tmr_q < cfg_i.turn_hold_ms) begin
        tmr_d = tmr_q + 10'd1;
      end
      if (tmr_d >= cfg_i.turn_hold_ms) begin
        ph_a = PhAlign;
      end
    end
    ph_d  = ph_a;
    drv_d = drv_q;
    idx_d = idx_q;
    if (cls_i.win_end) begin
      unique case (ph_a)
        PhFollow: begin
          if ({1'b0, idx_q} >= used_len) begin
            drv_d = DrvFwd;
            ph_d  = PhDone;
          end else if (!ml) begin
            drv_d = DrvRight;
            ph_d  = PhSteerR;
          end else if (!mr) begin
            drv_d = DrvLeft;
            ph_d  = PhSteerL;
          end else if (wing) begin
            if (code == CodeLeft || code == CodeRight) begin
              drv_d = (code == CodeLeft) ? DrvLeft : DrvRight;
              tmr_d = '0;
              ph_d  = PhHold;
            end else begin
              drv_d = DrvFwd;
              ph_d  = PhPass;
            end
          end
        end
        PhSteerR: begin
          if (ml) begin
            drv_d = DrvFwd;
            ph_d  = PhFollow;
          end
        end
        PhSteerL: begin
          if (mr) begin
            drv_d = DrvFwd;
            ph_d  = PhFollow;
          end
        end
        PhAlign, PhPass: begin
          if ((ph_a == PhAlign && ml && mr) || (ph_a == PhPass && !wing)) begin
            idx_d = idx_inc;
            drv_d = DrvFwd;
            ph_d  = ({1'b0, idx_inc} >= used_len) ? PhFin1 : PhFollow;
          end
        end
        PhFin1: begin
          if (!ml && mr) begin
            drv_d = DrvRight;
            ph_d  = PhFinR;
          end else begin
            drv_d = sc_drv;
            ph_d  = sc_ph;
          end
        end
        PhFinR: begin
          if (ml) begin
            drv_d = DrvFwd;
            ph_d  = PhFin2;
          end
        end
        PhFin2: begin
          drv_d = sc_drv;
          ph_d  = sc_ph;
        end
        PhFinL: begin
          if (mr) begin
            drv_d = DrvFwd;
            ph_d  = PhDone;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o.left_width     = (drv_d == DrvLeft) ? cfg_i.stop_width : cfg_i.forward_width;
    res_o.right_width    = (drv_d == DrvRight) ? cfg_i.stop_width : cfg_i.forward_width;
    res_o.route_position = idx_d;
    res_o.phase          = ph_d;
    res_o.done_res       = (ph_d == PhDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PhFollow;
      drv_q <= DrvFwd;
      idx_q <= '0;
      tmr_q <= '0;
    end else if (step) begin
      ph_q  <= ph_d;
      drv_q <= drv_d;
      idx_q <= idx_d;
      tmr_q <= tmr_d;
    end
  end

  a_done_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PhDone |-> drv_q == DrvFwd)
    else $error("done phase without forward drive");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, idx_q} <= RouteMaxW)
    else $error("route position beyond route maximum");

endmodule

[hw/rtl/line_follower_route_controller_core.sv]
// Top level of the line follower route controller.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  sample  | in        | push / full          | in_data_i  (in_item_t)
//  result  | out       | empty / pop          | out_data_o (out_item_t)
//  config  | in        | cfg_we_i, cfg_idx_i  | cfg_data_i (16 bits)
//
// One sample per cycle is accepted while full is low; each gives one result.
// A result reaches out_data_o when the phase update moves its sample from the
// sample queue into the result queue; that move waits while the result queue is full.
// Reset loads the register defaults and clears counters, phase and queues.
// A stalled result side fills the result queue, then the sample queue, then
// raises full; the back part stalls alone while the front still takes samples.
module line_follower_route_controller_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  lfrc_pkg::in_item_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output lfrc_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import lfrc_pkg::*;

  cfg_t      cfg_q;
  cls_item_t cls_in, cls_out;
  out_item_t res;
  logic      accept, cls_full, cls_empty, cls_pop, res_full, res_push;

  assign full   = cls_full;
  assign accept = push && !cls_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.route_codes   <= RouteCodesRst;
      cfg_q.route_length  <= RouteLengthRst;
      cfg_q.sample_window <= SampleWindowRst;
      cfg_q.qualify_bound <= QualifyBoundRst;
      cfg_q.turn_hold_ms  <= TurnHoldMsRst;
      cfg_q.forward_width <= ForwardWidthRst;
      cfg_q.stop_width    <= StopWidthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRouteCodes:   cfg_q.route_codes   <= cfg_data_i;
        RegRouteLength:  cfg_q.route_length  <= cfg_data_i[3:0];
        RegSampleWindow: cfg_q.sample_window <= cfg_data_i[7:0];
        RegQualifyBound: cfg_q.qualify_bound <= cfg_data_i[7:0];
        RegTurnHoldMs:   cfg_q.turn_hold_ms  <= cfg_data_i[9:0];
        RegForwardWidth: cfg_q.forward_width <= cfg_data_i[9:0];
        RegStopWidth:    cfg_q.stop_width    <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  lfrc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cls_o    (cls_in)
  );

  lfrc_fifo #(
    .Width ($bits(cls_item_t)),
    .Depth (2)
  ) u_cls_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (cls_full),
    .pop_i   (cls_pop),
    .data_o  (cls_out),
    .empty_o (cls_empty)
  );

  lfrc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (!cls_empty),
    .cls_i      (cls_out),
    .pop_o      (cls_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  lfrc_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule
